### hdl/fcv_pkg.sv
// fcv_pkg: types, constants and the crc-32 byte update for the firmware
// container verifier. No dependencies; used by firmware_container_verifier_top.
`default_nettype none

package fcv_pkg;

  localparam int unsigned CountWidth = 23;
  localparam int unsigned LenWidth   = CountWidth + 1;

  localparam logic [31:0] CRC_POLY        = 32'hEDB8_8320;
  localparam logic [31:0] CRC_ONES        = 32'hFFFF_FFFF;
  localparam logic [31:0] CONTAINER_MAGIC = 32'h5346_5743;
  localparam logic [7:0]  TARGET_RESET    = 8'h01;
  localparam logic [CountWidth-1:0] MAX_FILE_RESET = 23'd4194304;
  localparam logic [CountWidth-1:0] COUNT_MAX      = {CountWidth{1'b1}};
  localparam logic [CountWidth-1:0] HEADER_BYTES   = 23'd32;

  // register indexes on the configuration port
  localparam logic CFG_EXPECTED_TARGET = 1'b0;
  localparam logic CFG_MAX_FILE_BYTES  = 1'b1;

  // result status codes
  localparam logic [2:0] STATUS_CONTAINER_OK = 3'd0;
  localparam logic [2:0] STATUS_RAW_OK       = 3'd1;
  localparam logic [2:0] STATUS_WRONG_TARGET = 3'd2;
  localparam logic [2:0] STATUS_CRC_MISMATCH = 3'd3;
  localparam logic [2:0] STATUS_BAD_SIZE     = 3'd4;
  localparam logic [2:0] STATUS_TRUNCATED    = 3'd5;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        container_found;
    logic [31:0] computed_crc;
    logic [31:0] payload_length;
    logic [7:0]  version_major;
    logic [7:0]  version_minor;
    logic [7:0]  version_patch;
  } out_t;

  // reflected crc-32 over one byte; flattens to an xor network
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### hdl/firmware_container_verifier_top.sv
// firmware_container_verifier_top: header capture, crc-32 and result register.
// Depends on fcv_pkg for types, constants and the crc byte update.
//
// Usage: a firmware file streams in one byte per request on the in channel
// (valid/ready), the final byte flagged by last_byte. Header bytes update the
// header capture and payload bytes the running crc in the same cycle they are
// accepted, so a byte can be taken on every clock while in_ready_o is high:
// throughput is then one byte per cycle. The request carrying last_byte produces
// one result on the out channel, valid in the cycle after acceptance;
// other bytes produce no result. The result register parts the two sides:
// while the result waits on a stalled receiver, in_ready_o stays low, and it
// is high again in the cycle the result is taken, so the next file can start
// right away. After the last byte the file state returns to its reset value.
// The configuration port writes expected_target (index 0) and max_file_bytes
// (index 1); write them only while the block is idle.
// Reset (rst_ni low, asynchronous) clears the file state, drops out_valid_o
// and restores expected_target to 1 and max_file_bytes to 4194304.
`default_nettype none

module firmware_container_verifier_top (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic                  cfg_index_i,
  input  wire logic [22:0]           cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire fcv_pkg::in_t          in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output fcv_pkg::out_t              out_data_o
);

  logic [7:0]                       target_q;
  logic [fcv_pkg::CountWidth-1:0]   max_bytes_q;

  logic [fcv_pkg::CountWidth-1:0]   byte_count_q, byte_count_d;
  logic [31:0]                      magic_q, magic_d;
  logic [23:0]                      version_q, version_d;
  logic [7:0]                       target_id_q, target_id_d;
  logic [31:0]                      decl_len_q, decl_len_d;
  logic [31:0]                      exp_crc_q, exp_crc_d;
  logic [31:0]                      crc_q, crc_d;

  logic                             out_valid_q;
  fcv_pkg::out_t                    out_q, result_d;

  logic                             in_fire;
  logic                             in_header;
  logic [fcv_pkg::CountWidth-1:0]   pay_pos;
  logic                             in_payload;
  logic [fcv_pkg::LenWidth-1:0]     file_len;
  logic [31:0]                      crc_final;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // header bytes land in their own lanes; state is clear at file start
  assign in_header = (byte_count_q[fcv_pkg::CountWidth-1:4] == '0);
  assign pay_pos   = byte_count_q - fcv_pkg::HEADER_BYTES;
  assign in_payload = (byte_count_q >= fcv_pkg::HEADER_BYTES)
                   && (magic_q == fcv_pkg::CONTAINER_MAGIC)
                   && ({9'd0, pay_pos} < decl_len_q);

  always_comb begin
    magic_d     = magic_q;
    version_d   = version_q;
    target_id_d = target_id_q;
    decl_len_d  = decl_len_q;
    exp_crc_d   = exp_crc_q;
    crc_d       = crc_q;
    if (in_header) begin
      case (byte_count_q[3:2])
        2'd0: magic_d[8*byte_count_q[1:0] +: 8] = in_data_i.data_byte;
        2'd1: begin
          if (byte_count_q[1:0] == 2'd3) begin
            target_id_d = in_data_i.data_byte;
          end else begin
            version_d[8*byte_count_q[1:0] +: 8] = in_data_i.data_byte;
          end
        end
        2'd2: decl_len_d[8*byte_count_q[1:0] +: 8] = in_data_i.data_byte;
        2'd3: exp_crc_d[8*byte_count_q[1:0] +: 8] = in_data_i.data_byte;
        default: magic_d = magic_q;
      endcase
    end else if (in_payload) begin
      crc_d = fcv_pkg::crc_byte(crc_q, in_data_i.data_byte);
    end
    byte_count_d = (byte_count_q == fcv_pkg::COUNT_MAX) ? byte_count_q
                 : byte_count_q + 1'b1;
  end

  // result of the file ending with this byte
  assign file_len  = {1'b0, byte_count_q} + 1'b1;
  assign crc_final = crc_d ^ fcv_pkg::CRC_ONES;

  always_comb begin
    result_d = '0;
    if (file_len > {1'b0, max_bytes_q}) begin
      result_d.status = fcv_pkg::STATUS_BAD_SIZE;
    end else if ((file_len < {1'b0, fcv_pkg::HEADER_BYTES})
              || (magic_d != fcv_pkg::CONTAINER_MAGIC)) begin
      result_d.status = fcv_pkg::STATUS_RAW_OK;
    end else begin
      result_d.container_found = 1'b1;
      result_d.payload_length  = decl_len_d;
      result_d.version_major   = version_d[7:0];
      result_d.version_minor   = version_d[15:8];
      result_d.version_patch   = version_d[23:16];
      if (target_id_d != target_q) begin
        result_d.status = fcv_pkg::STATUS_WRONG_TARGET;
      end else if (decl_len_d >
                   {8'd0, file_len - {1'b0, fcv_pkg::HEADER_BYTES}}) begin
        result_d.status = fcv_pkg::STATUS_TRUNCATED;
      end else begin
        result_d.computed_crc = crc_final;
        result_d.status = (crc_final == exp_crc_d) ? fcv_pkg::STATUS_CONTAINER_OK
                                                   : fcv_pkg::STATUS_CRC_MISMATCH;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q    <= fcv_pkg::TARGET_RESET;
      max_bytes_q <= fcv_pkg::MAX_FILE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        fcv_pkg::CFG_EXPECTED_TARGET: target_q    <= cfg_data_i[7:0];
        fcv_pkg::CFG_MAX_FILE_BYTES:  max_bytes_q <= cfg_data_i;
        default:                      target_q    <= target_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q <= '0;
      magic_q      <= '0;
      version_q    <= '0;
      target_id_q  <= '0;
      decl_len_q   <= '0;
      exp_crc_q    <= '0;
      crc_q        <= fcv_pkg::CRC_ONES;
    end else if (in_fire) begin
      if (in_data_i.last_byte) begin
        byte_count_q <= '0;
        magic_q      <= '0;
        version_q    <= '0;
        target_id_q  <= '0;
        decl_len_q   <= '0;
        exp_crc_q    <= '0;
        crc_q        <= fcv_pkg::CRC_ONES;
      end else begin
        byte_count_q <= byte_count_d;
        magic_q      <= magic_d;
        version_q    <= version_d;
        target_id_q  <= target_id_d;
        decl_len_q   <= decl_len_d;
        exp_crc_q    <= exp_crc_d;
        crc_q        <= crc_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire && in_data_i.last_byte) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && in_data_i.last_byte) begin
      out_q <= result_d;
    end
  end

  // a last byte always yields a result and restarts the file state
  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_data_i.last_byte |=> out_valid_q
      && byte_count_q == '0 && crc_q == fcv_pkg::CRC_ONES)
    else $error("last byte did not produce a result or clear state");

  a_count_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !in_data_i.last_byte && byte_count_q != fcv_pkg::COUNT_MAX
      |=> byte_count_q == $past(byte_count_q) + 1'b1)
    else $error("byte count did not advance");

  a_ok_needs_container: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_q.status == fcv_pkg::STATUS_CONTAINER_OK
      || out_q.status == fcv_pkg::STATUS_CRC_MISMATCH) |-> out_q.container_found)
    else $error("crc status without a container");

  a_raw_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.container_found
      |-> out_q.computed_crc == '0 && out_q.payload_length == '0)
    else $error("header fields given without a container");

endmodule

`default_nettype wire

### sim/tb_top.sv
// tb_top: self-checking testbench for firmware_container_verifier_top.
// Streams directed and random firmware files and checks every result against a
// built-in predictor of the header capture and crc-32. Depends on fcv_pkg.

module tb_top;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          cfg_we = 1'b0;
  logic          cfg_index = fcv_pkg::CFG_EXPECTED_TARGET;
  logic [22:0]   cfg_data = '0;
  logic          in_valid = 1'b0;
  logic          in_ready;
  fcv_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  fcv_pkg::out_t out_data;

  firmware_container_verifier_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // predictor copy of the block state and registers
  logic [7:0]  cfg_target = fcv_pkg::TARGET_RESET;
  logic [22:0] cfg_max_bytes = fcv_pkg::MAX_FILE_RESET;
  logic [22:0] byte_count = '0;
  logic [31:0] magic_word = '0;
  logic [23:0] version_bytes = '0;
  logic [7:0]  target_id = '0;
  logic [31:0] declared_len = '0;
  logic [31:0] header_crc = '0;
  logic [31:0] payload_crc = fcv_pkg::CRC_ONES;

  fcv_pkg::out_t pending_results[$];
  logic [7:0]    file_bytes[$];

  int unsigned mismatch_count = 0;
  int unsigned results_seen = 0;
  int unsigned bytes_sent = 0;
  int unsigned send_idle_pct = 8;
  int unsigned recv_idle_pct = 75;
  int unsigned long_stall_len = 0;
  int unsigned stall_go = 0;
  int unsigned stall_ack = 0;
  int unsigned hold_left = 0;

  // bit-serial reflected crc-32, one byte lsb first
  function automatic logic [31:0] crc32_step(input logic [31:0] acc, input logic [7:0] data);
    logic [31:0] r;
    r = acc;
    for (int i = 0; i < 8; i++) begin
      if (r[0] ^ data[i]) r = (r >> 1) ^ fcv_pkg::CRC_POLY;
      else r = r >> 1;
    end
    return r;
  endfunction

  task automatic flag(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("error: %s", msg);
  endtask

  task automatic cmp_field(input string what, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) flag($sformatf("%s expected %h got %h", what, want, got));
  endtask

  task automatic absorb_byte(input fcv_pkg::in_t item);
    logic [22:0] pos;
    logic [23:0] len;
    fcv_pkg::out_t res;
    pos = byte_count;
    if (pos < 4) magic_word |= {24'd0, item.data_byte} << (8 * pos);
    else if (pos < 7) version_bytes |= {16'd0, item.data_byte} << (8 * (pos - 4));
    else if (pos == 7) target_id = item.data_byte;
    else if (pos < 12) declared_len |= {24'd0, item.data_byte} << (8 * (pos - 8));
    else if (pos < 16) header_crc |= {24'd0, item.data_byte} << (8 * (pos - 12));
    else if (pos >= fcv_pkg::HEADER_BYTES && magic_word == fcv_pkg::CONTAINER_MAGIC &&
             ({9'd0, pos} - 32'd32) < declared_len)
      payload_crc = crc32_step(payload_crc, item.data_byte);

    if (!item.last_byte) begin
      if (byte_count != fcv_pkg::COUNT_MAX) byte_count++;
    end else begin
      len = {1'b0, pos} + 24'd1;
      res = '0;
      if (len > {1'b0, cfg_max_bytes}) begin
        res.status = fcv_pkg::STATUS_BAD_SIZE;
      end else if (len < 24'd32 || magic_word != fcv_pkg::CONTAINER_MAGIC) begin
        res.status = fcv_pkg::STATUS_RAW_OK;
      end else begin
        res.container_found = 1'b1;
        res.payload_length = declared_len;
        res.version_major = version_bytes[7:0];
        res.version_minor = version_bytes[15:8];
        res.version_patch = version_bytes[23:16];
        if (target_id != cfg_target) begin
          res.status = fcv_pkg::STATUS_WRONG_TARGET;
        end else if (declared_len > {8'd0, len} - 32'd32) begin
          res.status = fcv_pkg::STATUS_TRUNCATED;
        end else begin
          res.computed_crc = payload_crc ^ fcv_pkg::CRC_ONES;
          res.status = (res.computed_crc == header_crc) ? fcv_pkg::STATUS_CONTAINER_OK
                                                        : fcv_pkg::STATUS_CRC_MISMATCH;
        end
      end
      pending_results.push_back(res);
      byte_count = '0;
      magic_word = '0;
      version_bytes = '0;
      target_id = '0;
      declared_len = '0;
      header_crc = '0;
      payload_crc = fcv_pkg::CRC_ONES;
    end
  endtask

  task automatic check_result(input fcv_pkg::out_t got);
    fcv_pkg::out_t want;
    results_seen++;
    if (pending_results.size() == 0) begin
      flag($sformatf("unexpected result, status %0d", got.status));
      return;
    end
    want = pending_results.pop_front();
    cmp_field("status", want.status, got.status);
    cmp_field("container_found", want.container_found, got.container_found);
    cmp_field("computed_crc", want.computed_crc, got.computed_crc);
    cmp_field("payload_length", want.payload_length, got.payload_length);
    cmp_field("version_major", want.version_major, got.version_major);
    cmp_field("version_minor", want.version_minor, got.version_minor);
    cmp_field("version_patch", want.version_patch, got.version_patch);
  endtask

  // all handshakes are sampled here, before the edge takes effect
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we) begin
        if (cfg_index == fcv_pkg::CFG_EXPECTED_TARGET) cfg_target = cfg_data[7:0];
        else cfg_max_bytes = cfg_data;
      end
      if (out_valid && out_ready) check_result(out_data);
      if (in_valid && in_ready) absorb_byte(in_data);
    end
  end

  // receiver: random idling, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (stall_go != stall_ack) begin
      stall_ack <= stall_go;
      hold_left <= long_stall_len;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_byte(input fcv_pkg::in_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk_i); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic send_file();
    fcv_pkg::in_t item;
    for (int i = 0; i < file_bytes.size(); i++) begin
      item.data_byte = file_bytes[i];
      item.last_byte = (i == file_bytes.size() - 1);
      send_byte(item);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [22:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic build_raw(input int unsigned n);
    file_bytes.delete();
    repeat (n) file_bytes.push_back(8'($urandom()));
  endtask

  task automatic build_container(input logic [7:0] target, input logic [23:0] version,
                                 input int unsigned pay_len, input logic [31:0] decl,
                                 input bit good_crc, input int unsigned trail);
    logic [31:0] crc;
    int unsigned covered;
    file_bytes.delete();
    for (int k = 0; k < 4; k++) file_bytes.push_back(fcv_pkg::CONTAINER_MAGIC[8*k +: 8]);
    for (int k = 0; k < 3; k++) file_bytes.push_back(version[8*k +: 8]);
    file_bytes.push_back(target);
    for (int k = 0; k < 4; k++) file_bytes.push_back(decl[8*k +: 8]);
    repeat (20) file_bytes.push_back(8'($urandom()));  // crc slot patched below
    repeat (pay_len + trail) file_bytes.push_back(8'($urandom()));
    covered = (decl < pay_len) ? decl : pay_len;
    crc = fcv_pkg::CRC_ONES;
    for (int i = 0; i < covered; i++) crc = crc32_step(crc, file_bytes[32 + i]);
    crc ^= fcv_pkg::CRC_ONES;
    if (!good_crc) crc ^= 32'h1 << $urandom_range(31);
    for (int k = 0; k < 4; k++) file_bytes[12 + k] = crc[8*k +: 8];
  endtask

  task automatic good_container(input logic [7:0] target, input int unsigned pay_len);
    build_container(target, 24'($urandom()), pay_len, pay_len, 1'b1, 0);
  endtask

  task automatic random_file();
    int unsigned kind;
    int unsigned pay;
    int unsigned trail;
    kind = $urandom_range(99);
    pay = $urandom_range(20);
    trail = ($urandom_range(3) == 0) ? $urandom_range(1, 4) : 0;
    if (kind < 45) begin
      build_container(cfg_target, 24'($urandom()), pay, pay, 1'b1, trail);
    end else if (kind < 55) begin
      build_container(cfg_target, 24'($urandom()), pay, pay, 1'b0, trail);
    end else if (kind < 63) begin
      build_container(cfg_target ^ 8'($urandom_range(1, 255)), 24'($urandom()), pay, pay,
                      1'b1, trail);
    end else if (kind < 73) begin
      if ($urandom_range(1)) build_container(cfg_target, 24'($urandom()), pay,
                                             pay + $urandom_range(1, 8), 1'b1, 0);
      else build_container(cfg_target, 24'($urandom()), pay, $urandom() | 32'h100, 1'b1, 0);
    end else if (kind < 80) begin
      build_container(cfg_target, 24'($urandom()), pay, pay, 1'b1, trail);
      file_bytes[$urandom_range(3)] ^= 8'h01 << $urandom_range(7);
    end else if (kind < 85) begin
      // valid magic but the file ends inside the header
      good_container(cfg_target, 0);
      while (file_bytes.size() > $urandom_range(4, 31)) void'(file_bytes.pop_back());
    end else if (kind < 93) begin
      build_raw($urandom_range(1, 31));
    end else begin
      build_raw($urandom_range(1, 64));
    end
  endtask

  task automatic test_reset_defaults();
    build_container(fcv_pkg::TARGET_RESET, 24'hFFFFFF, 0, 0, 1'b1, 0);
    send_file();
    build_container(fcv_pkg::TARGET_RESET, 24'h000000, 5, 5, 1'b1, 0);
    send_file();
    file_bytes = '{8'h00};
    send_file();
    file_bytes = '{8'hFF};
    send_file();
    good_container(fcv_pkg::TARGET_RESET, 0);
    void'(file_bytes.pop_back());
    send_file();
  endtask

  task automatic test_status_codes();
    good_container(8'h7E, 4);
    send_file();
    build_container(fcv_pkg::TARGET_RESET, 24'h010203, 9, 9, 1'b0, 0);
    send_file();
    build_container(fcv_pkg::TARGET_RESET, 24'h804020, 3, 32'hFFFFFFFF, 1'b1, 0);
    send_file();
    build_container(fcv_pkg::TARGET_RESET, 24'h0A0B0C, 6, 7, 1'b1, 0);
    send_file();
    build_container(fcv_pkg::TARGET_RESET, 24'hFF00FF, 7, 7, 1'b1, 5);
    send_file();
    good_container(fcv_pkg::TARGET_RESET, 2);
    file_bytes[3] ^= 8'h80;
    send_file();
  endtask

  task automatic test_config_extremes();
    write_reg(fcv_pkg::CFG_EXPECTED_TARGET, 23'd0);
    good_container(8'h00, 3);
    send_file();
    write_reg(fcv_pkg::CFG_EXPECTED_TARGET, 23'd255);
    good_container(8'hFF, 1);
    send_file();
    good_container(8'h00, 1);
    send_file();
    // a limit of zero rejects every file
    write_reg(fcv_pkg::CFG_MAX_FILE_BYTES, 23'd0);
    file_bytes = '{8'h5A};
    send_file();
    good_container(8'hFF, 0);
    send_file();
    write_reg(fcv_pkg::CFG_MAX_FILE_BYTES, 23'd1);
    file_bytes = '{8'hA5};
    send_file();
    build_raw(2);
    send_file();
    write_reg(fcv_pkg::CFG_MAX_FILE_BYTES, 23'd32);
    good_container(8'hFF, 0);
    send_file();
    good_container(8'hFF, 1);
    send_file();
    write_reg(fcv_pkg::CFG_MAX_FILE_BYTES, 23'h7FFFFF);
    good_container(8'hFF, 12);
    send_file();
    write_reg(fcv_pkg::CFG_EXPECTED_TARGET, {15'd0, fcv_pkg::TARGET_RESET});
    write_reg(fcv_pkg::CFG_MAX_FILE_BYTES, fcv_pkg::MAX_FILE_RESET);
  endtask

  // receiver holds off while files keep coming, so the result register fills
  task automatic test_backpressure();
    long_stall_len = 300;
    stall_go++;
    for (int i = 0; i < 8; i++) begin
      if (i[0]) good_container(cfg_target, 2);
      else build_raw(3);
      send_file();
    end
  endtask

  task automatic test_random_phase(input int unsigned s_idle, input int unsigned r_idle,
                                   input logic [7:0] target, input logic [22:0] max_bytes);
    int unsigned byte_start;
    int unsigned res_start;
    write_reg(fcv_pkg::CFG_EXPECTED_TARGET, {15'd0, target});
    write_reg(fcv_pkg::CFG_MAX_FILE_BYTES, max_bytes);
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    byte_start = bytes_sent;
    res_start = results_seen;
    while (bytes_sent - byte_start < 240 || results_seen - res_start < 14) begin
      random_file();
      send_file();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_status_codes();
    test_config_extremes();
    test_backpressure();
    test_random_phase(8, 75, 8'($urandom()), fcv_pkg::MAX_FILE_RESET);
    test_random_phase(75, 8, ($urandom_range(1) ? 8'hFF : 8'h00), 23'd48);
    test_random_phase(0, 0, 8'($urandom()), 23'h7FFFFF);
    drain();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
